// ===== src/iee_pkg.sv =====
package iee_pkg;

   // Default sizing of the lattice and the stored weights
   localparam int MAX_SITES_DEF   = 16;
   localparam int WEIGHT_BITS_DEF = 16;

   // Depth of the item queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request opcodes
   localparam logic [1:0] OP_WR_COUPLING = 2'd0;
   localparam logic [1:0] OP_WR_FIELD    = 2'd1;
   localparam logic [1:0] OP_EVALUATE    = 2'd2;

   // Configuration register indexes
   localparam logic CSR_ACTIVE_SITES = 1'b0;
   localparam logic CSR_SPIN_MODE    = 1'b1;

   // Kind of work the back end carries out for a queued item
   typedef enum logic [1:0] {
      KIND_WR_COUPLING = 2'd0,
      KIND_WR_FIELD    = 2'd1,
      KIND_EVALUATE    = 2'd2
   } item_kind_type;

   // One classified item as it waits in the queue
   typedef struct packed {
      item_kind_type      kind;
      logic [3:0]         row_index;
      logic [3:0]         col_index;
      logic signed [15:0] weight;
      logic [15:0]        spins;
      logic               include_pairs;
   } queue_entry_type;

   // Fill status of the queue
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [4:0] active_sites;
      logic       spin_mode;
   } cfg_type;

   // Sign and presence of one term travelling with a memory read
   typedef struct packed {
      logic valid;
      logic neg;
   } term_tag_type;

endpackage

// ===== src/iee_ram.sv =====
module iee_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/iee_front.sv =====
module iee_front #(
   parameter int MAX_SITES = iee_pkg::MAX_SITES_DEF
) (
   input  logic                      start,
   input  logic                      full,
   input  logic [1:0]                req_opcode,
   input  logic [3:0]                req_row_index,
   input  logic [3:0]                req_col_index,
   input  logic signed [15:0]        req_weight,
   input  logic [15:0]               req_spins,
   input  logic                      req_include_pairs,
   output logic                      push,
   output iee_pkg::queue_entry_type  entry
);

   logic accept;
   logic keep;
   logic row_ok;
   logic col_ok;

   assign accept = start && !full;
   assign row_ok = (32'(req_row_index) < MAX_SITES);
   assign col_ok = (32'(req_col_index) < MAX_SITES);

   // Classify the item; drop unused opcodes and writes outside the lattice
   always_comb begin
      keep       = 1'b0;
      entry.kind = iee_pkg::KIND_EVALUATE;
      unique case (req_opcode)
         iee_pkg::OP_WR_COUPLING: begin
            keep       = row_ok && col_ok;
            entry.kind = iee_pkg::KIND_WR_COUPLING;
         end
         iee_pkg::OP_WR_FIELD: begin
            keep       = row_ok;
            entry.kind = iee_pkg::KIND_WR_FIELD;
         end
         iee_pkg::OP_EVALUATE: begin
            keep       = 1'b1;
            entry.kind = iee_pkg::KIND_EVALUATE;
         end
         default: begin
            keep       = 1'b0;
            entry.kind = iee_pkg::KIND_EVALUATE;
         end
      endcase
      entry.row_index     = req_row_index;
      entry.col_index     = req_col_index;
      entry.weight        = req_weight;
      entry.spins         = req_spins;
      entry.include_pairs = req_include_pairs;
   end

   assign push = accept && keep;

endmodule

// ===== src/iee_queue.sv =====
module iee_queue #(
   parameter int DEPTH = iee_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  iee_pkg::queue_entry_type  push_entry,
   input  logic                      pop,
   output iee_pkg::queue_entry_type  head,
   output iee_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   iee_pkg::queue_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (32'(p) == DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (32'(count_ff) == DEPTH);

endmodule

// ===== src/iee_back.sv =====
module iee_back #(
   parameter int MAX_SITES   = iee_pkg::MAX_SITES_DEF,
   parameter int WEIGHT_BITS = iee_pkg::WEIGHT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  iee_pkg::cfg_type          cfg,
   input  iee_pkg::queue_entry_type  head,
   input  iee_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic signed [31:0]        rsp_energy_value
);

   localparam int SITE_W  = $clog2(MAX_SITES);
   localparam int CNT_W   = $clog2(MAX_SITES + 1);
   localparam int CDEPTH  = MAX_SITES * MAX_SITES;
   localparam int CADDR_W = $clog2(CDEPTH);
   localparam int ACC_RAW = WEIGHT_BITS + 2 * SITE_W + 2;
   localparam int ACC_W   = (ACC_RAW > 33) ? ACC_RAW : 33;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_SUM   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [SITE_W-1:0] i_ff, i_in;
   logic [SITE_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  jlim_ff, jlim_in;
   logic [15:0]       spins_ff, spins_in;
   logic              pairs_ff, pairs_in;
   logic              mode_ff, mode_in;
   iee_pkg::term_tag_type pair_tag_ff, pair_tag_in;
   iee_pkg::term_tag_type field_tag_ff, field_tag_in;
   logic signed [ACC_W-1:0] pair_acc_ff, pair_acc_in;
   logic signed [ACC_W-1:0] field_acc_ff, field_acc_in;
   logic signed [ACC_W-1:0] total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_energy_ff, rsp_energy_in;

   logic [CNT_W-1:0]  n_start;
   logic              c_wr_en;
   logic [CADDR_W-1:0] c_wr_addr;
   logic [CADDR_W-1:0] c_rd_addr;
   logic [WEIGHT_BITS-1:0] c_rd_data;
   logic              f_wr_en;
   logic [SITE_W-1:0] f_wr_addr;
   logic [WEIGHT_BITS-1:0] f_rd_data;
   logic [WEIGHT_BITS-1:0] w_store;
   logic              bit_i, bit_j;
   logic              last_i, last_j;
   logic signed [ACC_W-1:0] c_ext, f_ext;

   function automatic logic spin_bit(input logic [15:0] s, input int unsigned k);
      logic [3:0] low;
      low = 4'(k);
      return (k < 16) ? s[low] : 1'b0;
   endfunction

   // Convert the written weight to store width
   assign w_store   = WEIGHT_BITS'(head.weight);
   assign c_wr_addr = CADDR_W'(32'(head.row_index) * MAX_SITES + 32'(head.col_index));
   assign f_wr_addr = SITE_W'(head.row_index);
   assign c_rd_addr = CADDR_W'(32'(i_ff) * MAX_SITES + 32'(j_ff));

   iee_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (CDEPTH)
   ) u_coupling_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (w_store),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   iee_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (MAX_SITES)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (f_wr_en),
      .wr_addr (f_wr_addr),
      .wr_data (w_store),
      .rd_addr (i_ff),
      .rd_data (f_rd_data)
   );

   // Clamp the active site count to the lattice size
   always_comb begin
      if (32'(cfg.active_sites) > MAX_SITES) begin
         n_start = CNT_W'(MAX_SITES);
      end else begin
         n_start = CNT_W'(cfg.active_sites);
      end
   end

   assign bit_i  = spin_bit(spins_ff, 32'(i_ff));
   assign bit_j  = spin_bit(spins_ff, 32'(j_ff));
   assign last_i = (CNT_W'(i_ff) == n_ff - CNT_W'(1));
   assign last_j = (CNT_W'(j_ff) == jlim_ff - CNT_W'(1));
   assign c_ext  = ACC_W'($signed(c_rd_data));
   assign f_ext  = ACC_W'($signed(f_rd_data));

   // Carry out queued writes and sequence the walk over the stores and the final sum
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      jlim_in       = jlim_ff;
      spins_in      = spins_ff;
      pairs_in      = pairs_ff;
      mode_in       = mode_ff;
      pair_tag_in   = '0;
      field_tag_in  = '0;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_energy_in = rsp_energy_ff;
      pop           = 1'b0;
      c_wr_en       = 1'b0;
      f_wr_en       = 1'b0;

      // Accumulate the terms whose data just came out of the stores
      pair_acc_in  = pair_acc_ff;
      field_acc_in = field_acc_ff;
      if (pair_tag_ff.valid) begin
         pair_acc_in = pair_tag_ff.neg ? pair_acc_ff + c_ext : pair_acc_ff - c_ext;
      end
      if (field_tag_ff.valid) begin
         field_acc_in = field_tag_ff.neg ? field_acc_ff + f_ext : field_acc_ff - f_ext;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               unique case (head.kind)
                  iee_pkg::KIND_WR_COUPLING: c_wr_en = 1'b1;
                  iee_pkg::KIND_WR_FIELD:    f_wr_en = 1'b1;
                  iee_pkg::KIND_EVALUATE: begin
                     i_in         = '0;
                     j_in         = '0;
                     n_in         = n_start;
                     jlim_in      = head.include_pairs ? n_start : CNT_W'(1);
                     spins_in     = head.spins;
                     pairs_in     = head.include_pairs;
                     mode_in      = cfg.spin_mode;
                     pair_acc_in  = '0;
                     field_acc_in = '0;
                     state_in     = (n_start == '0) ? ST_SUM : ST_WALK;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_WALK: begin
            // Tag this read with the sign of the spin product
            pair_tag_in.valid  = pairs_ff && (i_ff != j_ff) &&
                                 (mode_ff || (bit_i && bit_j));
            pair_tag_in.neg    = mode_ff && (bit_i ^ bit_j);
            field_tag_in.valid = (j_ff == '0) && (mode_ff || bit_i);
            field_tag_in.neg   = mode_ff && !bit_i;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + SITE_W'(1);
               end
            end else begin
               j_in = j_ff + SITE_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            total_in = pair_acc_ff + field_acc_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Saturate to the 32-bit result range
            rsp_valid_in = 1'b1;
            if (total_ff > SAT_HI) begin
               rsp_energy_in = 32'sh7FFF_FFFF;
            end else if (total_ff < SAT_LO) begin
               rsp_energy_in = 32'sh8000_0000;
            end else begin
               rsp_energy_in = 32'(total_ff);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pair_tag_ff  <= '0;
         field_tag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pair_tag_ff  <= pair_tag_in;
         field_tag_ff <= field_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the working values of the current evaluation
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      n_ff          <= n_in;
      jlim_ff       <= jlim_in;
      spins_ff      <= spins_in;
      pairs_ff      <= pairs_in;
      mode_ff       <= mode_in;
      pair_acc_ff   <= pair_acc_in;
      field_acc_ff  <= field_acc_in;
      total_ff      <= total_in;
      rsp_energy_ff <= rsp_energy_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_energy_value = rsp_energy_ff;

endmodule

// ===== src/ising_energy_evaluator.sv =====
// The back end carries out write items from the queue head; one queues while another is
// carried out. An evaluation walks all active site pairs (each site once without pair
// terms) in ST_WALK, then ST_DRAIN, ST_SUM and ST_EMIT before the rsp_valid strobe, or
// goes straight to ST_SUM with no active site; it takes no new item until back in ST_IDLE.
// The walk makes one read of the coupling memory per cycle. A two-entry queue keeps busy
// low while an evaluation runs until two more items wait; results cannot stall.
// Reset (synchronous, active high) clears control state and sets 16 sites, +/-1 spins.
module ising_energy_evaluator #(
   parameter int MAX_SITES   = iee_pkg::MAX_SITES_DEF,
   parameter int WEIGHT_BITS = iee_pkg::WEIGHT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [15:0] req_weight,
   input  logic [15:0]        req_spins,
   input  logic               req_include_pairs,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_energy_value,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [4:0]         csr_write_data
);

   iee_pkg::cfg_type          cfg_ff, cfg_in;
   iee_pkg::queue_entry_type  push_entry;
   iee_pkg::queue_entry_type  head;
   iee_pkg::queue_status_type q_status;
   logic push;
   logic pop;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            iee_pkg::CSR_ACTIVE_SITES: cfg_in.active_sites = csr_write_data;
            iee_pkg::CSR_SPIN_MODE:    cfg_in.spin_mode    = csr_write_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_sites <= 5'd16;
         cfg_ff.spin_mode    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iee_front #(
      .MAX_SITES (MAX_SITES)
   ) u_front (
      .start             (start),
      .full              (q_status.full),
      .req_opcode        (req_opcode),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_weight        (req_weight),
      .req_spins         (req_spins),
      .req_include_pairs (req_include_pairs),
      .push              (push),
      .entry             (push_entry)
   );

   iee_queue #(
      .DEPTH (iee_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   iee_back #(
      .MAX_SITES   (MAX_SITES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_energy_value (rsp_energy_value)
   );

   assign busy = q_status.full;

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("item pushed into full queue");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // Results of two evaluations never come in adjacent cycles
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes back to back");

   // Leave reset with no result pending and room for an item
   a_reset_clean: assert property (@(posedge clock)
      $fell(reset) |-> (!rsp_valid && !busy))
      else $error("state not cleared by reset");

endmodule

// ===== tb/ising_energy_evaluator_tb.sv =====
`timescale 1ns / 100ps

module ising_energy_evaluator_tb;

   localparam int SITES = iee_pkg::MAX_SITES_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Leave room for the longest evaluation and the queued items behind it
   localparam int SETTLE_CYCLES = 300;
   localparam longint ENERGY_MAX = 64'sh7FFF_FFFF;
   localparam longint ENERGY_MIN = -64'sh8000_0000;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = iee_pkg::OP_WR_COUPLING;
   logic [3:0]         req_row_index = '0;
   logic [3:0]         req_col_index = '0;
   logic signed [15:0] req_weight = '0;
   logic [15:0]        req_spins = '0;
   logic               req_include_pairs = 1'b0;
   logic               rsp_valid;
   logic signed [31:0] rsp_energy_value;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = iee_pkg::CSR_ACTIVE_SITES;
   logic [4:0]         csr_write_data = '0;

   // Mirror of the block's stores and registers
   logic signed [15:0] coupling_weights [SITES][SITES];
   logic signed [15:0] field_weights [SITES];
   logic [4:0]         cfg_active_sites = 5'd16;
   logic               cfg_spin_mode = 1'b1;

   logic signed [31:0] pending_energies [$];
   logic signed [31:0] expected_energy;
   int                 error_count = 0;
   int                 calm_left = 0;

   ising_energy_evaluator dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_weight        (req_weight),
      .req_spins         (req_spins),
      .req_include_pairs (req_include_pairs),
      .rsp_valid         (rsp_valid),
      .rsp_energy_value  (rsp_energy_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Spin of one site under the current spin mode
   function automatic longint spin_value(input logic [15:0] spins, input int site);
      logic spin_bit;
      spin_bit = (site < 16) ? spins[site] : 1'b0;
      if (cfg_spin_mode)
         return spin_bit ? 64'sd1 : -64'sd1;
      return spin_bit ? 64'sd1 : 64'sd0;
   endfunction

   // Energy of a configuration: field terms, plus ordered pair terms when asked
   function automatic logic signed [31:0] compute_energy(input logic [15:0] spins,
                                                         input logic pairs);
      int     n;
      longint total;
      n = (cfg_active_sites > SITES) ? SITES : int'(cfg_active_sites);
      total = 0;
      if (pairs) begin
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
               if (i != j)
                  total -= longint'(coupling_weights[i][j]) * spin_value(spins, i)
                           * spin_value(spins, j);
      end
      for (int i = 0; i < n; i++)
         total -= longint'(field_weights[i]) * spin_value(spins, i);
      if (total > ENERGY_MAX)
         total = ENERGY_MAX;
      if (total < ENERGY_MIN)
         total = ENERGY_MIN;
      return total[31:0];
   endfunction

   // Weight with a bias toward the extremes
   function automatic logic signed [15:0] random_weight();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Send one item, then update the mirror once the block has taken it
   task automatic send_item(input logic [1:0] op, input logic [3:0] row,
                            input logic [3:0] col, input logic signed [15:0] w,
                            input logic [15:0] spins, input logic pairs);
      int gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         calm_left = $urandom_range(8, 30);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_weight <= w;
      req_spins <= spins;
      req_include_pairs <= pairs;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (op)
         iee_pkg::OP_WR_COUPLING: coupling_weights[row][col] = w;
         iee_pkg::OP_WR_FIELD:    field_weights[row] = w;
         iee_pkg::OP_EVALUATE:    pending_energies.push_back(compute_energy(spins, pairs));
         default: ;
      endcase
   endtask

   // Evaluate with random values on the fields the block ignores
   task automatic send_evaluate(input logic [15:0] spins, input logic pairs);
      send_item(iee_pkg::OP_EVALUATE, 4'($urandom), 4'($urandom), 16'($urandom), spins,
                pairs);
   endtask

   // Drop start, wait for every result, then let queued writes finish
   task automatic drain_and_settle();
      start <= 1'b0;
      while (pending_energies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers while the block is idle
   task automatic set_config(input logic [4:0] sites, input logic mode);
      drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_index <= iee_pkg::CSR_ACTIVE_SITES;
      csr_write_data <= sites;
      @(posedge clock);
      csr_index <= iee_pkg::CSR_SPIN_MODE;
      csr_write_data <= {4'($urandom), mode};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_active_sites = sites;
      cfg_spin_mode = mode;
   endtask

   // Fill every store entry so no evaluation reads an unwritten one
   task automatic test_load_stores();
      for (int i = 0; i < SITES; i++)
         send_item(iee_pkg::OP_WR_FIELD, 4'(i), 4'($urandom), random_weight(),
                   16'($urandom), 1'($urandom));
      for (int i = 0; i < SITES; i++)
         for (int j = 0; j < SITES; j++)
            send_item(iee_pkg::OP_WR_COUPLING, 4'(i), 4'(j), random_weight(),
                      16'($urandom), 1'($urandom));
   endtask

   // Extremes of the fields, every opcode, and the ignored opcode
   task automatic test_directed();
      send_evaluate(16'h0000, 1'b1);
      send_evaluate(16'hFFFF, 1'b1);
      send_evaluate(16'hFFFF, 1'b0);
      send_evaluate(16'h0000, 1'b0);
      send_item(iee_pkg::OP_WR_COUPLING, 4'd0, 4'd15, 16'sh7FFF, 16'h0000, 1'b0);
      send_item(iee_pkg::OP_WR_COUPLING, 4'd15, 4'd0, 16'sh8000, 16'hFFFF, 1'b1);
      // diagonal entries never enter the sum
      send_item(iee_pkg::OP_WR_COUPLING, 4'd15, 4'd15, 16'sh7FFF, 16'h0000, 1'b1);
      send_item(iee_pkg::OP_WR_FIELD, 4'd0, 4'd15, 16'sh8000, 16'hFFFF, 1'b0);
      send_item(iee_pkg::OP_WR_FIELD, 4'd15, 4'd0, 16'sh7FFF, 16'h0000, 1'b1);
      send_evaluate(16'h8001, 1'b1);
      send_evaluate(16'h7FFE, 1'b1);
      send_evaluate(16'h5555, 1'b1);
      send_evaluate(16'hAAAA, 1'b0);
      // unused opcode leaves the stores alone
      send_item(OP_UNUSED, 4'd15, 4'd0, 16'sh7FFF, 16'hFFFF, 1'b1);
      send_item(OP_UNUSED, 4'd0, 4'd15, 16'sh8000, 16'h0000, 1'b0);
      send_evaluate(16'hFFFF, 1'b1);
      send_item(iee_pkg::OP_WR_COUPLING, 4'd1, 4'd0, 16'sh8000, 16'h1234, 1'b0);
      send_evaluate(16'h0003, 1'b1);
      send_evaluate(16'h0001, 1'b1);
   endtask

   // Register extremes: zero sites, one site, full and above range, both spin modes
   task automatic test_config_extremes();
      logic [4:0] site_list [9];
      logic       mode_list [9];
      site_list = '{5'd0, 5'd0, 5'd1, 5'd1, 5'd16, 5'd31, 5'd31, 5'd17, 5'd2};
      mode_list = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
      for (int k = 0; k < 9; k++) begin
         set_config(site_list[k], mode_list[k]);
         send_evaluate(16'hFFFF, 1'b1);
         send_evaluate(16'($urandom), 1'b1);
         send_evaluate(16'($urandom), 1'b0);
      end
   endtask

   // Mixed writes and evaluations under a new setting per phase
   task automatic test_random_traffic();
      logic [4:0] sites;
      int         pick;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: sites = 5'd16;
            1: sites = 5'd1;
            2: sites = 5'd31;
            3: sites = 5'($urandom_range(2, 15));
            default: sites = 5'($urandom_range(0, 31));
         endcase
         set_config(sites, 1'($urandom));
         for (int k = 0; k < 40; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
               send_evaluate(16'($urandom), 1'($urandom));
            else if (pick < 14)
               send_item(iee_pkg::OP_WR_COUPLING, 4'($urandom), 4'($urandom),
                         random_weight(), 16'($urandom), 1'($urandom));
            else if (pick < 18)
               send_item(iee_pkg::OP_WR_FIELD, 4'($urandom), 4'($urandom),
                         random_weight(), 16'($urandom), 1'($urandom));
            else
               send_item(OP_UNUSED, 4'($urandom), 4'($urandom), random_weight(),
                         16'($urandom), 1'($urandom));
         end
      end
   endtask

   // Compare each energy with the oldest one expected
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_energies.size() == 0) begin
            $error("energy_value: no result expected, actual %0d", rsp_energy_value);
            error_count++;
         end else begin
            expected_energy = pending_energies.pop_front();
            if (rsp_energy_value !== expected_energy) begin
               $error("energy_value: expected %0d, actual %0d", expected_energy,
                      rsp_energy_value);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_stores();
      test_directed();
      test_config_extremes();
      test_random_traffic();
      drain_and_settle();
      if (error_count == 0 && pending_energies.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Hold a hard limit on the run
   initial begin
      #10ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
